@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SKT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a condition on the next edge.
`define SKT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// skt_pkg
// Types, codes and defaults shared by the sorted key table files.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

  localparam int DEFAULT_DEPTH = 64;

  // action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_FIND   = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  // status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND  = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] key;
    logic [15:0]        handle;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] found_handle;
    logic [6:0]  entry_count;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [15:0]        handle;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SRCH,
    S_SRCH_CMP,
    S_SHIFT
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/skt_entry_ram.sv @@
// ----------------------------------------------------------------------------
// skt_entry_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_entry_ram #(
  parameter int DEPTH = skt_pkg::DEFAULT_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire skt_pkg::entry_t wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output skt_pkg::entry_t      rd_data
);

  skt_pkg::entry_t mem [DEPTH];
  skt_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/core/sorted_key_table.sv @@
// ----------------------------------------------------------------------------
// sorted_key_table
// Ordered table of signed keys with handles: insert, find and remove.
// ----------------------------------------------------------------------------
// Each item runs a binary search of at most clog2(DEPTH+1) probes; an insert or
// remove that changes the table, not at its end, then shifts entries above the slot.
// One item at a time; busy drops with the result strobe, so the next word may
// be taken in the cycle the result is shown.
// Reset (rst_n low, synchronous) empties the table; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sorted_key_table #(
  parameter int DEPTH = skt_pkg::DEFAULT_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire skt_pkg::in_word_t in_data,
  output logic                   out_valid,
  output skt_pkg::out_word_t     out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  skt_pkg::state_t state_r, state_nxt;

  logic [1:0]         act_r, act_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic [15:0]        hnd_in_r, hnd_in_nxt;
  logic [CW-1:0]      lo_r, lo_nxt;
  logic [CW-1:0]      hi_r, hi_nxt;
  logic [AW-1:0]      mid_r, mid_nxt;
  logic               hit_r, hit_nxt;
  logic [15:0]        hit_hnd_r, hit_hnd_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic               reading_r, reading_nxt;
  logic               pend_r, pend_nxt;
  logic [AW-1:0]      pend_addr_r, pend_addr_nxt;
  logic               out_valid_r, out_valid_nxt;
  skt_pkg::out_word_t out_data_r, out_data_nxt;

  logic               ram_wr_en;
  logic [AW-1:0]      ram_wr_addr;
  skt_pkg::entry_t    ram_wr_data;
  logic               ram_rd_en;
  logic [AW-1:0]      ram_rd_addr;
  skt_pkg::entry_t    ram_rd_data;

  logic               srch_done;
  logic               full;
  logic [CW:0]        mid_sum;
  logic [AW-1:0]      mid_calc;
  logic [AW-1:0]      pos_idx;
  logic [AW-1:0]      fill_m1;
  logic               at_end;
  logic               need_shift;
  logic               shift_up;
  logic               shift_last;
  logic [31:0]        cnt_ext;

  skt_entry_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign srch_done = (lo_r == hi_r);
  assign full      = (fill_r == CW'(DEPTH));
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_calc  = mid_sum[AW:1];
  assign pos_idx   = lo_r[AW-1:0];
  assign fill_m1   = AW'(fill_r - CW'(1));
  assign shift_up  = (act_r == skt_pkg::ACT_INSERT);
  // lower bound sits past the last entry (insert) or on it (remove), so nothing above it moves
  assign at_end    = (act_r == skt_pkg::ACT_INSERT) ? (lo_r == fill_r)
                                                    : (lo_r == fill_r - CW'(1));
  assign need_shift = ((act_r == skt_pkg::ACT_INSERT) && !hit_r && !full && !at_end) ||
                      ((act_r == skt_pkg::ACT_REMOVE) && hit_r && !at_end);
  assign shift_last = shift_up ? (rd_ptr_r == pos_idx) : (rd_ptr_r == fill_m1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      skt_pkg::S_IDLE: begin
        if (start) state_nxt = skt_pkg::S_SRCH;
      end
      skt_pkg::S_SRCH: begin
        if (!srch_done)      state_nxt = skt_pkg::S_SRCH_CMP;
        else if (need_shift) state_nxt = skt_pkg::S_SHIFT;
        else                 state_nxt = skt_pkg::S_IDLE;
      end
      skt_pkg::S_SRCH_CMP: begin
        state_nxt = skt_pkg::S_SRCH;
      end
      skt_pkg::S_SHIFT: begin
        if (!reading_r && !pend_r) state_nxt = skt_pkg::S_IDLE;
      end
      default: state_nxt = skt_pkg::S_IDLE;
    endcase
  end

  // datapath, memory control and result
  always_comb begin
    act_nxt       = act_r;
    key_nxt       = key_r;
    hnd_in_nxt    = hnd_in_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    hit_nxt       = hit_r;
    hit_hnd_nxt   = hit_hnd_r;
    fill_nxt      = fill_r;
    rd_ptr_nxt    = rd_ptr_r;
    reading_nxt   = reading_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = pos_idx;
    ram_wr_data   = '{key: key_r, handle: hnd_in_r};
    ram_rd_en     = 1'b0;
    ram_rd_addr   = mid_calc;

    unique case (state_r)
      skt_pkg::S_IDLE: begin
        if (start) begin
          act_nxt     = in_data.action;
          key_nxt     = in_data.key;
          hnd_in_nxt  = in_data.handle;
          lo_nxt      = '0;
          hi_nxt      = fill_r;
          hit_nxt     = 1'b0;
          hit_hnd_nxt = '0;
        end
      end

      skt_pkg::S_SRCH: begin
        if (!srch_done) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = mid_calc;
          mid_nxt     = mid_calc;
        end else begin
          out_data_nxt.status       = skt_pkg::ST_NOTFOUND;
          out_data_nxt.found_handle = '0;
          case (act_r)
            skt_pkg::ACT_INSERT: begin
              if (hit_r) begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = skt_pkg::ST_DUPLICATE;
              end else if (full) begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = skt_pkg::ST_FULL;
              end else if (at_end) begin
                ram_wr_en           = 1'b1;
                fill_nxt            = fill_r + CW'(1);
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = skt_pkg::ST_INSERTED;
              end else begin
                rd_ptr_nxt  = fill_m1;
                reading_nxt = 1'b1;
                pend_nxt    = 1'b0;
              end
            end
            skt_pkg::ACT_FIND: begin
              out_valid_nxt = 1'b1;
              if (hit_r) begin
                out_data_nxt.status       = skt_pkg::ST_FOUND;
                out_data_nxt.found_handle = hit_hnd_r;
              end
            end
            skt_pkg::ACT_REMOVE: begin
              if (!hit_r) begin
                out_valid_nxt = 1'b1;
              end else if (at_end) begin
                fill_nxt                  = fill_r - CW'(1);
                out_valid_nxt             = 1'b1;
                out_data_nxt.status       = skt_pkg::ST_FOUND;
                out_data_nxt.found_handle = hit_hnd_r;
              end else begin
                rd_ptr_nxt  = pos_idx + AW'(1);
                reading_nxt = 1'b1;
                pend_nxt    = 1'b0;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      skt_pkg::S_SRCH_CMP: begin
        if (ram_rd_data.key < key_r) begin
          lo_nxt = CW'(mid_r) + CW'(1);
        end else begin
          hi_nxt      = CW'(mid_r);
          hit_nxt     = (ram_rd_data.key == key_r);
          hit_hnd_nxt = ram_rd_data.handle;
        end
      end

      skt_pkg::S_SHIFT: begin
        // write back the word read last cycle one slot over
        if (pend_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = shift_up ? (pend_addr_r + AW'(1)) : (pend_addr_r - AW'(1));
          ram_wr_data = ram_rd_data;
        end
        if (reading_r) begin
          ram_rd_en     = 1'b1;
          ram_rd_addr   = rd_ptr_r;
          pend_nxt      = 1'b1;
          pend_addr_nxt = rd_ptr_r;
          if (shift_last) reading_nxt = 1'b0;
          else            rd_ptr_nxt  = shift_up ? (rd_ptr_r - AW'(1)) : (rd_ptr_r + AW'(1));
        end else begin
          pend_nxt = 1'b0;
        end
        if (!reading_r && !pend_r) begin
          out_valid_nxt = 1'b1;
          if (shift_up) begin
            ram_wr_en                 = 1'b1;
            ram_wr_addr               = pos_idx;
            fill_nxt                  = fill_r + CW'(1);
            out_data_nxt.status       = skt_pkg::ST_INSERTED;
            out_data_nxt.found_handle = '0;
          end else begin
            fill_nxt                  = fill_r - CW'(1);
            out_data_nxt.status       = skt_pkg::ST_FOUND;
            out_data_nxt.found_handle = hit_hnd_r;
          end
        end
      end

      default: begin
      end
    endcase

    cnt_ext                  = 32'(fill_nxt);
    out_data_nxt.entry_count = cnt_ext[6:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skt_pkg::S_IDLE;
      fill_r      <= '0;
      reading_r   <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      reading_r   <= reading_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    key_r       <= key_nxt;
    hnd_in_r    <= hnd_in_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    hit_r       <= hit_nxt;
    hit_hnd_r   <= hit_hnd_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
    pend_addr_r <= pend_addr_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign busy      = (state_r != skt_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SKT_ASSERT(a_fill_bound, fill_r <= CW'(DEPTH), "fill count above depth")
  `SKT_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !out_valid, "accept without search")
  `SKT_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe held")
  `SKT_ASSERT(a_full_status, !out_valid || (out_data.status != skt_pkg::ST_FULL) ||
              full, "full status on a table that is not full")

endmodule

`default_nettype wire
